### rtl/csim_pkg.sv
// Shared types, widths and step counts for the streaming cosine similarity block.
package csim_pkg;

    // Field and accumulator widths.
    localparam int ELEM_W = 16;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int ACC_W  = 48;
    localparam int COS_W  = 16;

    // Back engine widths: squares and products of 48-bit magnitudes, remainder scaled by 2^32.
    localparam int HALF_W = ACC_W / 2;
    localparam int WIDE_W = 2 * ACC_W;
    localparam int QUO_W  = 32;
    localparam int REM_W  = WIDE_W + QUO_W;
    localparam int ROOT_W = QUO_W / 2;

    // Step counts of the back engine phases.
    localparam int MUL_STEPS  = 8;
    localparam int DIV_STEPS  = QUO_W + 2;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int CNT_W      = 6;

    localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(MUL_STEPS - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_STEPS - 1);
    localparam logic [CNT_W-1:0] DIV_INIT_STEP = CNT_W'(0);
    localparam logic [CNT_W-1:0] DIV_SAT_STEP  = CNT_W'(1);

    // Saturation limits.
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [COS_W-1:0] COS_MAX = {1'b0, {(COS_W-1){1'b1}}};

    // Input request: one element pair.
    typedef struct packed {
        logic signed [ELEM_W-1:0] a_value;
        logic signed [ELEM_W-1:0] b_value;
        logic                     last;
        logic                     missing;
    } in_t;

    // Output request: one similarity result.
    typedef struct packed {
        logic signed [COS_W-1:0] cosine;
        logic                    zero_result;
        logic                    overflow;
    } out_t;

    // Final sums of one vector pair, handed to the back engine.
    typedef struct packed {
        logic [ACC_W-1:0]   dmag;
        logic               neg;
        logic [ACC_W-2:0]   norm_a;
        logic [ACC_W-2:0]   norm_b;
        logic               zero;
        logic               ovf;
    } fin_t;

    // Status from the accumulator to the controller.
    typedef struct packed {
        logic last_pend;
        logic zero;
    } acc_stat_t;

    // Commands from the controller.
    typedef struct packed {
        logic             hold;
        logic             capture;
        logic             mul_step;
        logic             div_init;
        logic             div_sat;
        logic             div_step;
        logic             sqrt_step;
        logic             out_load;
        logic [CNT_W-1:0] step;
    } ctrl_cmd_t;

    // Saturating accumulate; the top bit of the result flags saturation.
    function automatic logic [ACC_W:0] sat_add(
        input logic signed [ACC_W-1:0]  acc,
        input logic signed [PROD_W-1:0] p
    );
        logic signed [ACC_W:0] s;
        logic [ACC_W:0]        r;
        s = (ACC_W+1)'(acc) + (ACC_W+1)'(p);
        if (!s[ACC_W] && s[ACC_W-1])
        begin
            r = {1'b1, ACC_MAX};
        end
        else if (s[ACC_W] && !s[ACC_W-1])
        begin
            r = {1'b1, ACC_MIN};
        end
        else
        begin
            r = {1'b0, s[ACC_W-1:0]};
        end
        return r;
    endfunction

endpackage

### rtl/csim_accum.sv
// Element product stage and saturating dot product and norm accumulators.
module csim_accum (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  elem_valid,
    input  csim_pkg::in_t         elem,
    input  logic                  hold,
    output csim_pkg::acc_stat_t   stat,
    output csim_pkg::fin_t        fin
);

    logic pipe_valid_reg, pipe_valid_next;
    logic pipe_last_reg, pipe_missing_reg;
    logic signed [csim_pkg::PROD_W-1:0] pab_reg, paa_reg, pbb_reg;
    logic signed [csim_pkg::PROD_W-1:0] pab_next, paa_next, pbb_next;

    logic signed [csim_pkg::ACC_W-1:0] dot_reg, norm_a_reg, norm_b_reg;
    logic signed [csim_pkg::ACC_W-1:0] dot_sum, norm_a_sum, norm_b_sum;
    logic missing_seen_reg, overflow_seen_reg;
    logic ov_dot, ov_a, ov_b;
    logic missing_all, overflow_all;
    logic advance;

    // Products of the incoming pair, registered ahead of the adders.
    assign pab_next = elem.a_value * elem.b_value;
    assign paa_next = elem.a_value * elem.a_value;
    assign pbb_next = elem.b_value * elem.b_value;

    assign pipe_valid_next = hold ? pipe_valid_reg : elem_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_valid_reg <= 1'b0;
        end
        else
        begin
            pipe_valid_reg <= pipe_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (elem_valid && !hold)
        begin
            pab_reg          <= pab_next;
            paa_reg          <= paa_next;
            pbb_reg          <= pbb_next;
            pipe_last_reg    <= elem.last;
            pipe_missing_reg <= elem.missing;
        end
    end

    // Saturating sums including the pair in the product stage.
    assign {ov_dot, dot_sum}    = csim_pkg::sat_add(dot_reg, pab_reg);
    assign {ov_a, norm_a_sum}   = csim_pkg::sat_add(norm_a_reg, paa_reg);
    assign {ov_b, norm_b_sum}   = csim_pkg::sat_add(norm_b_reg, pbb_reg);

    assign missing_all  = missing_seen_reg | pipe_missing_reg;
    assign overflow_all = overflow_seen_reg | ov_dot | ov_a | ov_b;
    assign advance      = pipe_valid_reg & ~hold;

    assign stat.last_pend = pipe_valid_reg & pipe_last_reg;
    assign stat.zero      = missing_all || (norm_a_sum == '0) || (norm_b_sum == '0);

    // Final values of the vector pair; norms are never negative.
    assign fin.dmag   = dot_sum[csim_pkg::ACC_W-1] ? (csim_pkg::ACC_W'(0) - dot_sum) : dot_sum;
    assign fin.neg    = dot_sum[csim_pkg::ACC_W-1];
    assign fin.norm_a = norm_a_sum[csim_pkg::ACC_W-2:0];
    assign fin.norm_b = norm_b_sum[csim_pkg::ACC_W-2:0];
    assign fin.zero   = stat.zero;
    assign fin.ovf    = overflow_all;

    // Accumulate, or clear once the last pair has been handed on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg           <= '0;
            norm_a_reg        <= '0;
            norm_b_reg        <= '0;
            missing_seen_reg  <= 1'b0;
            overflow_seen_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (pipe_last_reg)
            begin
                dot_reg           <= '0;
                norm_a_reg        <= '0;
                norm_b_reg        <= '0;
                missing_seen_reg  <= 1'b0;
                overflow_seen_reg <= 1'b0;
            end
            else
            begin
                dot_reg           <= dot_sum;
                norm_a_reg        <= norm_a_sum;
                norm_b_reg        <= norm_b_sum;
                missing_seen_reg  <= missing_all;
                overflow_seen_reg <= overflow_all;
            end
        end
    end

endmodule

### rtl/csim_ctrl.sv
// Controller state machine sequencing the multiply, divide and square root phases.
module csim_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  csim_pkg::acc_stat_t   stat,
    input  logic                  result_stall,
    output csim_pkg::ctrl_cmd_t   cmd,
    output logic                  result_valid
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_SQRT = 3'd3;
    localparam logic [2:0] ST_PUT  = 3'd4;

    logic [2:0]                 state_reg, state_next;
    logic [csim_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       out_free;

    assign out_free = ~out_valid_reg | ~result_stall;

    // Next state and commands.
    always_comb
    begin
        cmd            = '0;
        cmd.step       = cnt_reg;
        cmd.hold       = stat.last_pend & (state_reg != ST_IDLE);
        cmd.capture    = stat.last_pend & (state_reg == ST_IDLE);
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = stat.zero ? ST_PUT : ST_MUL;
                    cnt_next   = '0;
                end
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (cnt_reg == csim_pkg::MUL_LAST)
                begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == csim_pkg::DIV_INIT_STEP)
                begin
                    cmd.div_init = 1'b1;
                end
                else if (cnt_reg == csim_pkg::DIV_SAT_STEP)
                begin
                    cmd.div_sat = 1'b1;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
                if (cnt_reg == csim_pkg::DIV_LAST)
                begin
                    state_next = ST_SQRT;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == csim_pkg::SQRT_LAST)
                begin
                    state_next = ST_PUT;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_PUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    // The result stays valid until it is taken.
    assign out_valid_next = cmd.out_load ? 1'b1 : (out_valid_reg & result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

### rtl/csim_dpath.sv
// Back engine datapath: split multiplier, restoring divider, integer square root, result register.
module csim_dpath (
    input  logic                  clk,
    input  csim_pkg::ctrl_cmd_t   cmd,
    input  csim_pkg::fin_t        fin,
    output csim_pkg::out_t        result
);

    localparam int AW = csim_pkg::ACC_W;
    localparam int HW = csim_pkg::HALF_W;
    localparam int WW = csim_pkg::WIDE_W;
    localparam int RW = csim_pkg::REM_W;
    localparam int QW = csim_pkg::QUO_W;
    localparam int SW = csim_pkg::ROOT_W;

    // Captured final sums.
    logic [AW-1:0] dmag_reg;
    logic          neg_reg;
    logic [AW-2:0] norm_a_reg, norm_b_reg;
    logic          zero_reg, ovf_reg;

    // Multiplier, divider and root state.
    logic [WW-1:0] sq_reg, pr_reg;
    logic [RW-1:0] rem_reg, div_reg;
    logic [QW-1:0] q_reg;
    logic          sat_reg;
    logic [SW-1:0] s_reg;
    csim_pkg::out_t result_reg, result_next;

    logic [AW-1:0] mul_x, mul_y;
    logic [HW-1:0] x_half, y_half;
    logic [AW-1:0] pp;
    logic [WW-1:0] term;
    logic          ge;
    logic [QW-1:0] q_eff;
    logic [$clog2(SW)-1:0] bit_pos;
    logic [SW-1:0] cand;
    logic [QW-1:0] cand_sq;
    logic [SW:0]   k_round;
    logic [SW-1:0] k;

    // One 24 by 24 partial product per cycle: four for dot^2, four for norm_a*norm_b.
    assign mul_x  = cmd.step[2] ? {1'b0, norm_a_reg} : dmag_reg;
    assign mul_y  = cmd.step[2] ? {1'b0, norm_b_reg} : dmag_reg;
    assign x_half = cmd.step[1] ? mul_x[AW-1:HW] : mul_x[HW-1:0];
    assign y_half = cmd.step[0] ? mul_y[AW-1:HW] : mul_y[HW-1:0];
    assign pp     = x_half * y_half;

    always_comb
    begin
        unique case (cmd.step[1:0])
            2'b00:   term = WW'(pp);
            2'b01:   term = WW'(pp) << HW;
            2'b10:   term = WW'(pp) << HW;
            default: term = WW'(pp) << AW;
        endcase
    end

    // Divider compare, shared by the saturation check and the quotient steps.
    assign ge = (rem_reg >= div_reg);

    // Root candidate: set the next bit and test its square against the quotient.
    assign q_eff   = sat_reg ? '1 : q_reg;
    assign bit_pos = $clog2(SW)'(SW - 1) - cmd.step[$clog2(SW)-1:0];
    assign cand    = s_reg | (SW'(1) << bit_pos);
    assign cand_sq = cand * cand;

    // Round the root to the index k = (s + 1) / 2 and apply the sign.
    assign k_round = {1'b0, s_reg} + (SW+1)'(1);
    assign k       = k_round[SW:1];

    always_comb
    begin
        result_next.zero_result = zero_reg;
        result_next.overflow    = ovf_reg;
        if (zero_reg)
        begin
            result_next.cosine = '0;
        end
        else if (neg_reg)
        begin
            result_next.cosine = csim_pkg::COS_W'(0) - k;
        end
        else if (k[SW-1])
        begin
            result_next.cosine = csim_pkg::COS_MAX;
        end
        else
        begin
            result_next.cosine = k;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            dmag_reg   <= fin.dmag;
            neg_reg    <= fin.neg;
            norm_a_reg <= fin.norm_a;
            norm_b_reg <= fin.norm_b;
            zero_reg   <= fin.zero;
            ovf_reg    <= fin.ovf;
            sq_reg     <= '0;
            pr_reg     <= '0;
        end
        else if (cmd.mul_step)
        begin
            if (cmd.step[2])
            begin
                pr_reg <= pr_reg + term;
            end
            else
            begin
                sq_reg <= sq_reg + term;
            end
        end

        // Quotient of dot^2 * 2^32 over norm_a * norm_b, capped at 32 bits.
        if (cmd.div_init)
        begin
            rem_reg <= {sq_reg, {QW{1'b0}}};
            div_reg <= {pr_reg, {QW{1'b0}}};
            q_reg   <= '0;
            sat_reg <= 1'b0;
            s_reg   <= '0;
        end
        else if (cmd.div_sat)
        begin
            sat_reg <= ge;
            div_reg <= div_reg >> 1;
        end
        else if (cmd.div_step)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - div_reg;
            end
            q_reg   <= {q_reg[QW-2:0], ge};
            div_reg <= div_reg >> 1;
        end
        else if (cmd.sqrt_step)
        begin
            if (cand_sq <= q_eff)
            begin
                s_reg <= cand;
            end
        end

        if (cmd.out_load)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

### rtl/cosine_similarity_stream_core.sv
// Top level of the streaming cosine similarity block.
// Element pairs of two Q4.12 vectors are taken one per cycle while elem_stall is low; each
// pair is multiplied in a product stage and added into saturating 48-bit dot product and norm
// accumulators. The pair marked last hands the sums to a back engine and clears the
// accumulators, so the next vector pair streams in at once while the result is worked out.
// The back engine accumulates 24-bit partial products, runs a restoring division and an
// integer square root, then loads the output register; a result forced to zero goes straight
// to the load. A further last pair waits with elem_stall high until the engine is free and its
// result register can be loaded. The result is cosine in Q1.15 rounded to nearest, zero_result
// when a norm is zero or a pair was missing, and overflow when an accumulator saturated.
module cosine_similarity_stream_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            elem_valid,
    output logic            elem_stall,
    input  csim_pkg::in_t   elem,
    output logic            result_valid,
    input  logic            result_stall,
    output csim_pkg::out_t  result
);

    csim_pkg::acc_stat_t stat;
    csim_pkg::fin_t      fin;
    csim_pkg::ctrl_cmd_t cmd;

    // Front accumulation.
    csim_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .elem_valid (elem_valid),
        .elem       (elem),
        .hold       (cmd.hold),
        .stat       (stat),
        .fin        (fin)
    );

    // Sequencer for the back engine and the output handshake.
    csim_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .stat         (stat),
        .result_stall (result_stall),
        .cmd          (cmd),
        .result_valid (result_valid)
    );

    // Back engine datapath.
    csim_dpath u_dpath (
        .clk    (clk),
        .cmd    (cmd),
        .fin    (fin),
        .result (result)
    );

    assign elem_stall = cmd.hold;

    // A captured vector pair keeps the engine busy for at least the next cycle.
    a_single_capture: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> !cmd.capture)
        else $error("back engine captured two vector pairs in a row");

    // Only one datapath command is active in any cycle.
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.mul_step, cmd.div_init, cmd.div_sat, cmd.div_step,
                  cmd.sqrt_step, cmd.out_load}))
        else $error("conflicting datapath commands");

    // A forced-zero result carries a zero cosine.
    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (!result.zero_result || (result.cosine == '0)))
        else $error("zero_result with nonzero cosine");

endmodule

### test/cosine_similarity_stream_core_tb.sv
// Self-checking testbench for the streaming cosine similarity core.
module cosine_similarity_stream_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT    = 300_000;
    localparam int unsigned RANDOM_PAIRS   = 660;
    localparam int unsigned LONG_PAIRS     = 64;
    localparam int unsigned IDLE_PCT       = 19;
    localparam int unsigned TAIL_CYCLES    = 100;
    localparam int unsigned CALM_FIRST     = 250;
    localparam int unsigned CALM_LAST      = 400;

    localparam logic signed [csim_pkg::ELEM_W-1:0] ONE_Q12     = 16'sd4096;
    localparam logic signed [csim_pkg::COS_W-1:0]  COS_NEG_ONE =
        {1'b1, {(csim_pkg::COS_W-1){1'b0}}};

    // Shapes of random vector pairs.
    typedef enum int {
        SHAPE_NOISE,
        SHAPE_ALIGNED,
        SHAPE_OPPOSED,
        SHAPE_ZERO_A,
        SHAPE_TINY
    } shape_t;

    // One row of the directed stimulus; want is used only when typed is set.
    typedef struct {
        csim_pkg::in_t  req;
        bit             typed;
        csim_pkg::out_t want;
    } row_t;

    logic           clk;
    logic           rst_n        = 1'b0;
    logic           elem_valid   = 1'b0;
    logic           elem_stall;
    csim_pkg::in_t  elem         = '0;
    logic           result_valid;
    logic           result_stall = 1'b0;
    csim_pkg::out_t result;

    // Typed expectation travelling with the request currently offered.
    logic           typed_valid  = 1'b0;
    csim_pkg::out_t typed_want   = '0;

    // No idling on either side while set.
    logic calm         = 1'b0;

    // Predictor state: accumulated sums and per-vector flags.
    logic signed [csim_pkg::ACC_W-1:0] dot_sum  = '0;
    logic signed [csim_pkg::ACC_W-1:0] energy_a = '0;
    logic signed [csim_pkg::ACC_W-1:0] energy_b = '0;
    bit absent_seen = 1'b0;
    bit clamp_seen  = 1'b0;

    csim_pkg::out_t owed_results[$];
    int unsigned mismatches = 0;

    cosine_similarity_stream_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .elem_valid   (elem_valid),
        .elem_stall   (elem_stall),
        .elem         (elem),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Saturating add into a 48-bit accumulator; records any clamp.
    function automatic logic signed [csim_pkg::ACC_W-1:0] clamp_add(
        input logic signed [csim_pkg::ACC_W-1:0]  acc,
        input logic signed [csim_pkg::PROD_W-1:0] prod
    );
        logic signed [csim_pkg::ACC_W+1:0] s;
        s = acc + prod;
        if (s > csim_pkg::ACC_MAX)
        begin
            clamp_seen = 1'b1;
            return csim_pkg::ACC_MAX;
        end
        if (s < csim_pkg::ACC_MIN)
        begin
            clamp_seen = 1'b1;
            return csim_pkg::ACC_MIN;
        end
        return s[csim_pkg::ACC_W-1:0];
    endfunction

    // Exact round-to-nearest of dot / sqrt(na * nb) in Q1.15. The magnitude k is the
    // largest one with (2|dot| * 2^15)^2 >= (2k - 1)^2 * na * nb, capped at 2^15.
    function automatic logic signed [csim_pkg::COS_W-1:0] q15_cosine(
        input logic signed [csim_pkg::ACC_W-1:0] dot,
        input logic [csim_pkg::ACC_W-1:0]        na,
        input logic [csim_pkg::ACC_W-1:0]        nb
    );
        logic [csim_pkg::ACC_W-1:0] mag;
        logic [63:0]      m;
        logic [95:0]      norm_prod;
        logic [159:0]     lhs;
        logic [159:0]     rhs;
        logic [16:0]      lo;
        logic [16:0]      hi;
        logic [16:0]      mid;
        logic [16:0]      odd;
        mag = (dot < 0) ? csim_pkg::ACC_W'(-dot) : csim_pkg::ACC_W'(dot);
        m = {mag, 16'b0};
        norm_prod = 96'(na) * 96'(nb);
        lhs = 160'(m) * 160'(m);
        lo = '0;
        hi = 17'd32768;
        while (lo < hi)
        begin
            mid = 17'((lo + hi + 1) / 2);
            odd = 17'(2 * mid - 1);
            rhs = 160'(norm_prod) * 160'(odd) * 160'(odd);
            if (lhs >= rhs)
                lo = mid;
            else
                hi = mid - 17'd1;
        end
        if (dot < 0)
            return csim_pkg::COS_W'(17'd0 - lo);
        if (lo > 17'd32767)
            return csim_pkg::COS_MAX;
        return lo[csim_pkg::COS_W-1:0];
    endfunction

    // Adds one element pair into the sums; returns 1 with the result on the last pair.
    function automatic bit accumulate_pair(input csim_pkg::in_t p, output csim_pkg::out_t res);
        logic signed [csim_pkg::PROD_W-1:0] ab;
        logic signed [csim_pkg::PROD_W-1:0] aa;
        logic signed [csim_pkg::PROD_W-1:0] bb;
        bit zero;
        res = '0;
        ab = p.a_value * p.b_value;
        aa = p.a_value * p.a_value;
        bb = p.b_value * p.b_value;
        dot_sum  = clamp_add(dot_sum, ab);
        energy_a = clamp_add(energy_a, aa);
        energy_b = clamp_add(energy_b, bb);
        if (p.missing)
            absent_seen = 1'b1;
        if (!p.last)
            return 1'b0;
        zero = absent_seen || energy_a == 0 || energy_b == 0;
        res.cosine = zero ? '0 : q15_cosine(dot_sum, energy_a, energy_b);
        res.zero_result = zero;
        res.overflow = clamp_seen;
        dot_sum  = '0;
        energy_a = '0;
        energy_b = '0;
        absent_seen = 1'b0;
        clamp_seen  = 1'b0;
        return 1'b1;
    endfunction

    function automatic row_t directed_row(
        input int a, input int b, input int last, input int missing,
        input int typed, input int cos, input int zero
    );
        row_t r;
        r.req.a_value = csim_pkg::ELEM_W'(a);
        r.req.b_value = csim_pkg::ELEM_W'(b);
        r.req.last    = 1'(last);
        r.req.missing = 1'(missing);
        r.typed       = 1'(typed);
        r.want.cosine      = csim_pkg::COS_W'(cos);
        r.want.zero_result = 1'(zero);
        r.want.overflow    = 1'b0;
        return r;
    endfunction

    // Offers one request after a random idle gap and returns once it is taken.
    task automatic send_pair(input csim_pkg::in_t p, input bit typed,
                             input csim_pkg::out_t want);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            elem_valid <= 1'b0;
            @(negedge clk);
        end
        elem        <= p;
        typed_valid <= typed;
        typed_want  <= want;
        elem_valid  <= 1'b1;
        @(posedge clk);
        while (elem_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Holds off the sender until every owed result has come back.
    task automatic drain_results();
        elem_valid <= 1'b0;
        do
            @(negedge clk);
        while (owed_results.size() != 0);
    endtask

    // Receiver stalls at random outside the calm stretch.
    always @(negedge clk)
    begin
        result_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // Check results against the oldest expectation, then predict for accepted requests.
    always @(posedge clk)
    begin : scoreboard
        csim_pkg::out_t want;
        csim_pkg::out_t made;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (owed_results.size() == 0)
                begin
                    $display("%0t: unexpected result cosine %0d zero %0b overflow %0b",
                             $time, result.cosine, result.zero_result, result.overflow);
                    mismatches++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (result.cosine !== want.cosine)
                    begin
                        $display("%0t: cosine expected %0d actual %0d",
                                 $time, want.cosine, result.cosine);
                        mismatches++;
                    end
                    if (result.zero_result !== want.zero_result)
                    begin
                        $display("%0t: zero_result expected %0b actual %0b",
                                 $time, want.zero_result, result.zero_result);
                        mismatches++;
                    end
                    if (result.overflow !== want.overflow)
                    begin
                        $display("%0t: overflow expected %0b actual %0b",
                                 $time, want.overflow, result.overflow);
                        mismatches++;
                    end
                end
            end
            if (elem_valid && !elem_stall)
            begin
                if (accumulate_pair(elem, made))
                    owed_results = {owed_results, typed_valid ? typed_want : made};
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("cosine_similarity_stream_core regression: fail");
        $finish;
    end

    initial
    begin
        row_t        rows[$];
        csim_pkg::in_t pair;
        int unsigned sent;
        int unsigned len;
        int          miss_at;
        shape_t      shape;
        logic signed [csim_pkg::ELEM_W-1:0] a;
        logic signed [csim_pkg::ELEM_W-1:0] b;

        // Directed rows: unit and opposite vectors, zero norms, missing pairs, extremes.
        rows = {rows, directed_row(4096, 4096, 1, 0, 1, csim_pkg::COS_MAX, 0)};
        rows = {rows, directed_row(4096, -4096, 1, 0, 1, COS_NEG_ONE, 0)};
        rows = {rows, directed_row(0, 0, 1, 0, 1, 0, 1)};
        rows = {rows, directed_row(0, 4096, 1, 0, 1, 0, 1)};
        rows = {rows, directed_row(4096, 0, 1, 0, 1, 0, 1)};
        rows = {rows, directed_row(4096, 4096, 0, 1, 0, 0, 0)};
        rows = {rows, directed_row(4096, 4096, 1, 0, 1, 0, 1)};
        rows = {rows, directed_row(1000, 2000, 1, 1, 1, 0, 1)};
        rows = {rows, directed_row(-32768, -32768, 1, 0, 1, csim_pkg::COS_MAX, 0)};
        rows = {rows, directed_row(32767, -32768, 1, 0, 1, COS_NEG_ONE, 0)};
        rows = {rows, directed_row(32767, 32767, 1, 0, 1, csim_pkg::COS_MAX, 0)};
        rows = {rows, directed_row(-1, 1, 1, 0, 1, COS_NEG_ONE, 0)};
        rows = {rows, directed_row(4096, 0, 0, 0, 0, 0, 0)};
        rows = {rows, directed_row(0, 4096, 1, 0, 1, 0, 0)};
        rows = {rows, directed_row(0, 5, 0, 0, 0, 0, 0)};
        rows = {rows, directed_row(0, -3, 1, 0, 1, 0, 1)};
        rows = {rows, directed_row(4096, 4096, 0, 0, 0, 0, 0)};
        rows = {rows, directed_row(4096, 0, 1, 0, 0, 0, 0)};
        rows = {rows, directed_row(3, 5, 0, 0, 0, 0, 0)};
        rows = {rows, directed_row(-7, 11, 0, 0, 0, 0, 0)};
        rows = {rows, directed_row(21845, -21846, 0, 0, 0, 0, 0)};
        rows = {rows, directed_row(-32768, 32767, 1, 0, 0, 0, 0)};
        rows = {rows, directed_row(1234, -567, 0, 0, 0, 0, 0)};
        rows = {rows, directed_row(-2048, ONE_Q12, 1, 0, 0, 0, 0)};

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
            send_pair(rows[i].req, rows[i].typed, rows[i].want);
        drain_results();

        // One long vector of extreme elements: the sums grow large and the dot product
        // is strongly negative, so the cosine is exactly -1.
        pair.a_value = 16'sh8000;
        pair.b_value = 16'sh7FFF;
        pair.missing = 1'b0;
        for (int unsigned i = 0; i < LONG_PAIRS; i++)
        begin
            pair.last = (i == LONG_PAIRS - 1);
            send_pair(pair, 1'b0, '0);
        end
        drain_results();

        // Random vector pairs, mostly short, of several shapes.
        sent = 0;
        while (sent < RANDOM_PAIRS)
        begin
            if ($urandom_range(99) < 80)
                len = $urandom_range(8, 1);
            else
                len = $urandom_range(40, 9);
            shape = shape_t'($urandom_range(SHAPE_TINY, SHAPE_NOISE));
            miss_at = ($urandom_range(9) == 0) ? int'($urandom_range(len - 1)) : -1;
            for (int unsigned i = 0; i < len; i++)
            begin
                a = csim_pkg::ELEM_W'($urandom);
                b = csim_pkg::ELEM_W'($urandom);
                case (shape)
                    SHAPE_ALIGNED: b = a + csim_pkg::ELEM_W'($urandom_range(63)) - 16'sd32;
                    SHAPE_OPPOSED: b = -a + csim_pkg::ELEM_W'($urandom_range(63)) - 16'sd32;
                    SHAPE_ZERO_A:  a = '0;
                    SHAPE_TINY:
                    begin
                        a = csim_pkg::ELEM_W'($urandom_range(16)) - 16'sd8;
                        b = csim_pkg::ELEM_W'($urandom_range(16)) - 16'sd8;
                    end
                    default: ;
                endcase
                pair.a_value = a;
                pair.b_value = b;
                pair.last    = (i == len - 1);
                pair.missing = (int'(i) == miss_at) || ($urandom_range(99) == 0);
                calm <= (sent >= CALM_FIRST) && (sent < CALM_LAST);
                send_pair(pair, 1'b0, '0);
                sent++;
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && owed_results.size() == 0)
            $display("cosine_similarity_stream_core regression: pass");
        else
            $display("cosine_similarity_stream_core regression: fail");
        $finish;
    end

endmodule
